FILE: rtl/irpfr_pkg.sv
`default_nettype none

package irpfr_pkg;

    localparam int TIMER_W   = 8;
    localparam int CFG_W     = 8;
    localparam int FRAME_W   = 13;
    localparam int IDX_W     = 4;
    localparam int DATA_W    = 6;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    localparam logic [IDX_W-1:0]   LAST_BIT      = IDX_W'(12);
    localparam logic [4:0]         FRAME_TAG     = 5'h05;
    localparam logic [CFG_W-1:0]   LONG_WAIT_RST = CFG_W'(161);
    localparam logic [CFG_W-1:0]   BIT_WAIT_RST  = CFG_W'(77);
    localparam logic [CFG_W-1:0]   SAMPLE_RST    = CFG_W'(57);

    // request codes
    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_EDGE = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    // register indexes, paddr[3:2]
    localparam logic [1:0] REG_LONG_WAIT = 2'd0;
    localparam logic [1:0] REG_BIT_WAIT  = 2'd1;
    localparam logic [1:0] REG_SAMPLE    = 2'd2;

    typedef struct packed {
        logic [CFG_W-1:0] long_wait;
        logic [CFG_W-1:0] bit_wait;
        logic [CFG_W-1:0] sample_delay;
    } t_cfg;

    typedef struct packed {
        logic             started;
        logic             waiting;
        logic [IDX_W-1:0] bit_index;
    } t_status;

endpackage

`default_nettype wire

FILE: rtl/irpfr_cfg.sv
`default_nettype none

module irpfr_cfg
    import irpfr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output t_cfg                    o_cfg
);

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic [1:0] reg_sel;
    logic       wr_en;

    assign reg_sel = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_sel)
                REG_LONG_WAIT: n_cfg.long_wait    = pwdata[CFG_W-1:0];
                REG_BIT_WAIT:  n_cfg.bit_wait     = pwdata[CFG_W-1:0];
                REG_SAMPLE:    n_cfg.sample_delay = pwdata[CFG_W-1:0];
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_LONG_WAIT: prdata = PDATA_W'(r_cfg.long_wait);
            REG_BIT_WAIT:  prdata = PDATA_W'(r_cfg.bit_wait);
            REG_SAMPLE:    prdata = PDATA_W'(r_cfg.sample_delay);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_wait    <= LONG_WAIT_RST;
            r_cfg.bit_wait     <= BIT_WAIT_RST;
            r_cfg.sample_delay <= SAMPLE_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/irpfr_core.sv
`default_nettype none

module irpfr_core
    import irpfr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic [1:0]        i_req_type,
    input  wire logic              i_pin_level,
    input  wire t_cfg              i_cfg,
    output logic                   o_data_ready,
    output logic      [DATA_W-1:0] o_read_data,
    output t_status                o_status
);

    logic               r_idle,    n_idle;
    logic               r_started, n_started;
    logic               r_waiting, n_waiting;
    logic               r_timeout, n_timeout;
    logic               r_ready,   n_ready;
    logic               r_running, n_running;
    logic [IDX_W-1:0]   r_idx,     n_idx;
    logic [FRAME_W-1:0] r_frame,   n_frame;
    logic [TIMER_W-1:0] r_count,   n_count;
    logic [CFG_W-1:0]   r_limit,   n_limit;
    logic [DATA_W-1:0]  rd_data;
    logic               expiry;

    assign expiry = r_running && (r_count == TIMER_W'(r_limit));

    always_comb begin
        n_idle    = r_idle;
        n_started = r_started;
        n_waiting = r_waiting;
        n_timeout = r_timeout;
        n_ready   = r_ready;
        n_running = r_running;
        n_idx     = r_idx;
        n_frame   = r_frame;
        n_count   = r_count;
        n_limit   = r_limit;
        rd_data   = '0;
        case (i_req_type)
            REQ_TICK: begin
                if (r_running && !expiry) begin
                    n_count = r_count + 1'b1;
                end else if (expiry) begin
                    n_count = '0;
                    if (r_timeout) begin
                        // second expiry without an edge stops the timer
                        n_running = 1'b0;
                        n_idle    = 1'b1;
                        n_started = 1'b0;
                        n_waiting = 1'b0;
                        n_idx     = '0;
                        n_ready   = 1'b0;
                        n_frame   = '0;
                        n_timeout = 1'b0;
                    end else if (!r_started && !i_pin_level) begin
                        // bad start level, index cleared
                        n_timeout = 1'b0;
                        n_limit   = i_cfg.bit_wait;
                        n_idle    = 1'b1;
                        n_waiting = 1'b0;
                        n_idx     = '0;
                        n_ready   = 1'b0;
                        n_frame   = '0;
                    end else begin
                        n_timeout = 1'b1;
                        n_limit   = i_cfg.bit_wait;
                        if (r_started) begin
                            // active-low data, shift of 1 past the top gives 0
                            if (!i_pin_level) begin
                                n_frame = r_frame | (FRAME_W'(1) << r_idx);
                            end
                            n_waiting = 1'b0;
                        end else begin
                            n_started = 1'b1;
                        end
                        n_idx = r_idx + 1'b1;
                        if (n_idx > LAST_BIT) begin
                            n_idle    = 1'b1;
                            n_started = 1'b0;
                            n_waiting = 1'b0;
                            n_idx     = '0;
                            if (n_frame[FRAME_W-1:8] == FRAME_TAG) begin
                                n_ready = 1'b1;
                            end else begin
                                n_ready   = 1'b0;
                                n_frame   = '0;
                                n_timeout = 1'b0;
                            end
                        end
                    end
                end
            end
            REQ_EDGE: begin
                n_timeout = 1'b0;
                if (r_idle) begin
                    n_idle    = 1'b0;
                    n_frame   = '0;
                    n_count   = '0;
                    n_limit   = i_cfg.long_wait;
                    n_running = 1'b1;
                end else if (r_started && !r_waiting) begin
                    n_waiting = 1'b1;
                    n_count   = '0;
                    n_limit   = i_cfg.sample_delay;
                    n_running = 1'b1;
                end else begin
                    n_idle    = 1'b1;
                    n_started = 1'b0;
                    n_waiting = 1'b0;
                    n_idx     = '0;
                    n_ready   = 1'b0;
                    n_frame   = '0;
                end
            end
            REQ_READ: begin
                if (r_ready) begin
                    n_ready = 1'b0;
                    rd_data = r_frame[DATA_W:1];
                end
            end
            default: begin
                n_ready = r_ready;
            end
        endcase
    end

    assign o_data_ready       = n_ready;
    assign o_read_data        = rd_data;
    assign o_status.started   = r_started;
    assign o_status.waiting   = r_waiting;
    assign o_status.bit_index = r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle    <= 1'b1;
            r_started <= 1'b0;
            r_waiting <= 1'b0;
            r_timeout <= 1'b0;
            r_ready   <= 1'b0;
            r_running <= 1'b0;
            r_idx     <= '0;
            r_frame   <= '0;
            r_count   <= '0;
            r_limit   <= '0;
        end else if (i_step) begin
            r_idle    <= n_idle;
            r_started <= n_started;
            r_waiting <= n_waiting;
            r_timeout <= n_timeout;
            r_ready   <= n_ready;
            r_running <= n_running;
            r_idx     <= n_idx;
            r_frame   <= n_frame;
            r_count   <= n_count;
            r_limit   <= n_limit;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ir_pulse_frame_receiver_core.sv
// channel   direction  handshake                  payload
// request   in         i_in_valid / o_in_ready    i_req_type, i_pin_level
// result    out        o_out_valid / i_out_ready  o_data_ready, o_read_data
// config    in         apb psel / penable         paddr, pwdata, prdata
//
// one word per cycle unless stalled: state updates at the accepting edge and
// the result is registered at that same edge, offered from the next cycle
// a request word is taken whenever the output register is empty or draining
// synchronous active-low reset: idle, timer stopped, limits at defaults
`default_nettype none

module ir_pulse_frame_receiver_core
    import irpfr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [1:0]         i_req_type,
    input  wire logic               i_pin_level,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic                    o_data_ready,
    output logic      [DATA_W-1:0]  o_read_data,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    t_cfg              cfg;
    t_status           status;
    logic              step;
    logic              res_ready;
    logic [DATA_W-1:0] res_data;
    logic              r_out_valid;
    logic              r_out_ready_flag;
    logic [DATA_W-1:0] r_out_data;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign step       = i_in_valid && o_in_ready;

    irpfr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    irpfr_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_req_type   (i_req_type),
        .i_pin_level  (i_pin_level),
        .i_cfg        (cfg),
        .o_data_ready (res_ready),
        .o_read_data  (res_data),
        .o_status     (status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_ready_flag <= res_ready;
            r_out_data       <= res_data;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_data_ready = r_out_ready_flag;
    assign o_read_data  = r_out_data;

    // no bit is counted before the start level has been seen
    a_idx_needs_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !status.started |-> status.bit_index == '0)
        else $error("bit index moved without a start");

    a_wait_needs_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.waiting |-> status.started)
        else $error("sample wait outside a frame");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.bit_index <= LAST_BIT)
        else $error("bit index past frame end");

    // a read that returns data always consumes the frame
    a_read_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_read_data != '0) |-> !o_data_ready)
        else $error("ready still set after data read");

endmodule

`default_nettype wire
